// ----- hw/rtl/ate_pkg.sv -----
// shared types and constants for the token eviction table
// no dependencies

package ate_pkg;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_EVICT  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  localparam int unsigned MAX_VICTIMS = 64;
  localparam int unsigned VIC_AW      = 6;
  localparam int unsigned CNT_W       = 7;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_IDLE = 3'd1;
  localparam logic [2:0] OP_SCAN = 3'd2;
  localparam logic [2:0] OP_MARK = 3'd3;
  localparam logic [2:0] OP_COMP = 3'd4;
  localparam logic [2:0] OP_FIN  = 3'd5;
  localparam logic [2:0] OP_ERD  = 3'd6;
  localparam logic [2:0] OP_ELD  = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       accept;
  } cmd_t;

  typedef struct packed {
    logic ev_go;
    logic sweep_done;
    logic found;
    logic taken_last;
    logic has_victims;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/ate_ctrl.sv -----
// sequencing state machine of the token eviction table
// depends on ate_pkg

module ate_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ate_pkg::sts_t sts_i,
  output ate_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_ERD  = 3'd6;
  localparam logic [2:0] S_ELD  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = accept;
    cmd_o.op      = ate_pkg::OP_IDLE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = ate_pkg::OP_INIT;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.op = ate_pkg::OP_IDLE;
        if (accept && sts_i.ev_go) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.op = ate_pkg::OP_SCAN;
        if (sts_i.sweep_done) state_d = S_MARK;
      end
      S_MARK: begin
        cmd_o.op = ate_pkg::OP_MARK;
        if (!sts_i.found || sts_i.taken_last) state_d = S_COMP;
        else state_d = S_SCAN;
      end
      S_COMP: begin
        cmd_o.op = ate_pkg::OP_COMP;
        if (sts_i.sweep_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = ate_pkg::OP_FIN;
        state_d  = sts_i.has_victims ? S_ERD : S_ELD;
      end
      S_ERD: begin
        cmd_o.op = ate_pkg::OP_ERD;
        state_d  = S_ELD;
      end
      S_ELD: begin
        cmd_o.op = ate_pkg::OP_ELD;
        if (sts_i.out_free) state_d = sts_i.emit_last ? S_IDLE : S_ERD;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/ate_dpath.sv -----
// table memories, sweep pipeline, victim buffer and result register
// depends on ate_pkg

module ate_dpath #(
  parameter int unsigned SLOTS         = 512,
  parameter int unsigned WEIGHT_BITS   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ate_pkg::cmd_t cmd_i,
  output ate_pkg::sts_t sts_o,
  input  logic [1:0]    mode_i,
  input  logic [8:0]    slot_index_i,
  input  logic [15:0]   weight_i,
  input  logic [31:0]   new_position_i,
  input  logic [9:0]    budget_i,
  input  logic [6:0]    room_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [1:0]    status_o,
  output logic [31:0]   victim_position_o,
  output logic          victim_valid_o,
  output logic          last_o,
  output logic [9:0]    size_after_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W = ate_pkg::CNT_W;
  localparam logic [31:0] WMAX = 32'((64'd1 << WEIGHT_BITS) - 64'd1);

  logic [POSITION_BITS-1:0] pos_mem [SLOTS];
  logic [WEIGHT_BITS-1:0]   w_mem   [SLOTS];
  logic                     obs_mem [SLOTS];
  logic                     doom_mem[SLOTS];
  logic [POSITION_BITS-1:0] vic_mem [ate_pkg::MAX_VICTIMS];

  logic [CW-1:0]            occ_q, occ_d, idx_q, idx_d, pidx_q, wr_q, wr_d;
  logic                     pv_q, found_q, found_d;
  logic [AW-1:0]            best_q, best_d;
  logic [WEIGHT_BITS-1:0]   bw_q, bw_d;
  logic [CNT_W-1:0]         need_q, need_d, taken_q, taken_d;
  logic [CNT_W-1:0]         vcnt_q, vcnt_d, ecnt_q, ecnt_d;
  logic [POSITION_BITS-1:0] pos_rd_q, vic_rd_q;
  logic [WEIGHT_BITS-1:0]   w_rd_q;
  logic                     obs_rd_q, doom_rd_q;

  logic                     out_valid_q, out_valid_d, load;
  logic [1:0]               out_status_q, out_status_d;
  logic [31:0]              out_pos_q, out_pos_d;
  logic                     out_vv_q, out_vv_d, out_last_q, out_last_d;
  logic [9:0]               out_size_q, out_size_d;

  logic                     issue, cand, out_free, full, slot_ok;
  logic [31:0]              occ32, bud32, need32;
  logic [6:0]               room_sat;
  logic [WEIGHT_BITS-1:0]   w_sat;
  logic [AW-1:0]            raddr;

  logic                     pos_we, w_we, obs_we, doom_we, vic_we;
  logic [AW-1:0]            pos_wa, w_wa, obs_wa, doom_wa;
  logic [POSITION_BITS-1:0] pos_wd;
  logic [WEIGHT_BITS-1:0]   w_wd;
  logic                     obs_wd, doom_wd;

  assign out_free = !out_valid_q || !out_stall_i;
  assign occ32    = 32'(occ_q);
  assign bud32    = 32'(budget_i);
  assign need32   = occ32 - bud32;
  assign room_sat = (room_i > 7'(ate_pkg::MAX_VICTIMS)) ? 7'(ate_pkg::MAX_VICTIMS) : room_i;
  assign w_sat    = (32'(weight_i) > WMAX) ? WEIGHT_BITS'(WMAX) : WEIGHT_BITS'(weight_i);
  assign full     = (occ_q == CW'(SLOTS));
  assign slot_ok  = 32'(slot_index_i) < occ32;
  assign issue    = ((cmd_i.op == ate_pkg::OP_SCAN) || (cmd_i.op == ate_pkg::OP_COMP))
                    && (idx_q != occ_q);
  assign raddr    = AW'(idx_q);
  assign cand     = pv_q && !doom_rd_q && obs_rd_q && (!found_q || (w_rd_q < bw_q));

  assign sts_o.ev_go       = (mode_i == ate_pkg::MODE_EVICT) && (occ32 > bud32)
                             && (need32 <= 32'(room_sat));
  assign sts_o.sweep_done  = !pv_q && (idx_q == occ_q);
  assign sts_o.found       = found_q;
  assign sts_o.taken_last  = (taken_q + CNT_W'(1)) == need_q;
  assign sts_o.has_victims = (vcnt_q != '0);
  assign sts_o.emit_last   = (ecnt_q + CNT_W'(1)) >= vcnt_q;
  assign sts_o.out_free    = out_free;

  always_comb begin
    occ_d   = occ_q;
    idx_d   = idx_q;
    wr_d    = wr_q;
    found_d = found_q;
    best_d  = best_q;
    bw_d    = bw_q;
    need_d  = need_q;
    taken_d = taken_q;
    vcnt_d  = vcnt_q;
    ecnt_d  = ecnt_q;
    pos_we  = 1'b0; pos_wa  = '0; pos_wd  = '0;
    w_we    = 1'b0; w_wa    = '0; w_wd    = '0;
    obs_we  = 1'b0; obs_wa  = '0; obs_wd  = 1'b0;
    doom_we = 1'b0; doom_wa = '0; doom_wd = 1'b0;
    vic_we  = 1'b0;
    load         = 1'b0;
    out_status_d = ate_pkg::STATUS_OK;
    out_pos_d    = '0;
    out_vv_d     = 1'b0;
    out_last_d   = 1'b1;
    out_size_d   = 10'(occ_q);
    if (issue) idx_d = idx_q + CW'(1);
    unique case (cmd_i.op)
      ate_pkg::OP_INIT: begin
        pos_we = 1'b1; obs_we = 1'b1; doom_we = 1'b1;
      end
      ate_pkg::OP_IDLE: begin
        if (cmd_i.accept) begin
          priority case (mode_i)
            ate_pkg::MODE_WEIGHT: begin
              load = 1'b1;
              if (slot_ok) begin
                w_we = 1'b1; w_wa = AW'(slot_index_i); w_wd = w_sat;
                obs_we = 1'b1; obs_wa = AW'(slot_index_i); obs_wd = 1'b1;
              end
            end
            ate_pkg::MODE_APPEND: begin
              load = 1'b1;
              if (full) begin
                out_status_d = ate_pkg::STATUS_FULL;
              end else begin
                pos_we  = 1'b1; pos_wa  = AW'(occ_q);
                pos_wd  = POSITION_BITS'(new_position_i);
                obs_we  = 1'b1; obs_wa  = AW'(occ_q);
                doom_we = 1'b1; doom_wa = AW'(occ_q);
                occ_d      = occ_q + CW'(1);
                out_size_d = 10'(occ_q + CW'(1));
              end
            end
            ate_pkg::MODE_EVICT: begin
              if (sts_o.ev_go) begin
                need_d  = CNT_W'(need32);
                taken_d = '0;
                idx_d   = '0;
                found_d = 1'b0;
                wr_d    = '0;
                vcnt_d  = '0;
              end else begin
                load = 1'b1;
                if (occ32 > bud32) out_status_d = ate_pkg::STATUS_REFUSED;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      ate_pkg::OP_SCAN: begin
        if (cand) begin
          found_d = 1'b1;
          best_d  = AW'(pidx_q);
          bw_d    = w_rd_q;
        end
      end
      ate_pkg::OP_MARK: begin
        if (found_q) begin
          doom_we = 1'b1; doom_wa = best_q; doom_wd = 1'b1;
          taken_d = taken_q + CNT_W'(1);
        end
        idx_d   = '0;
        found_d = 1'b0;
      end
      ate_pkg::OP_COMP: begin
        if (pv_q) begin
          if (doom_rd_q) begin
            doom_we = 1'b1; doom_wa = AW'(pidx_q);
            vic_we  = 1'b1;
            vcnt_d  = vcnt_q + CNT_W'(1);
          end else begin
            pos_we = 1'b1; pos_wa = AW'(wr_q); pos_wd = pos_rd_q;
            w_we   = 1'b1; w_wa   = AW'(wr_q); w_wd   = w_rd_q;
            obs_we = 1'b1; obs_wa = AW'(wr_q); obs_wd = obs_rd_q;
            wr_d   = wr_q + CW'(1);
          end
        end
      end
      ate_pkg::OP_FIN: begin
        occ_d  = wr_q;
        ecnt_d = '0;
      end
      ate_pkg::OP_ERD: begin
      end
      ate_pkg::OP_ELD: begin
        if (out_free) begin
          load       = 1'b1;
          out_vv_d   = sts_o.has_victims;
          out_pos_d  = sts_o.has_victims ? 32'(vic_rd_q) : '0;
          out_last_d = sts_o.emit_last;
          ecnt_d     = ecnt_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_q <= pos_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    w_rd_q <= w_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (obs_we) obs_mem[obs_wa] <= obs_wd;
    obs_rd_q <= obs_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (doom_we) doom_mem[doom_wa] <= doom_wd;
    doom_rd_q <= doom_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vic_we) vic_mem[vcnt_q[ate_pkg::VIC_AW-1:0]] <= pos_rd_q;
    vic_rd_q <= vic_mem[ecnt_q[ate_pkg::VIC_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_vv_q     <= out_vv_d;
      out_last_q   <= out_last_d;
      out_size_q   <= out_size_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= CW'(1);
      idx_q       <= '0;
      pidx_q      <= '0;
      pv_q        <= 1'b0;
      wr_q        <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      bw_q        <= '0;
      need_q      <= '0;
      taken_q     <= '0;
      vcnt_q      <= '0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      pidx_q      <= idx_q;
      pv_q        <= issue;
      wr_q        <= wr_d;
      found_q     <= found_d;
      best_q      <= best_d;
      bw_q        <= bw_d;
      need_q      <= need_d;
      taken_q     <= taken_d;
      vcnt_q      <= vcnt_d;
      ecnt_q      <= ecnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign victim_position_o = out_pos_q;
  assign victim_valid_o    = out_vv_q;
  assign last_o            = out_last_q;
  assign size_after_o      = out_size_q;

endmodule

// ----- hw/rtl/attention_token_eviction_table.sv -----
// Token eviction table: weight and append words each give one result.
// An evict word that proceeds runs up to one minimum search sweep per victim needed,
// one sweep over occupancy for compaction, then a read state and a load state per
// victim word out, all through the single read port of the table memories.
// After reset the init state writes entry zero before the first word is taken.
// depends on ate_pkg, ate_ctrl, ate_dpath

module attention_token_eviction_table #(
  parameter int unsigned SLOTS         = 512,
  parameter int unsigned WEIGHT_BITS   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [8:0]  slot_index_i,
  input  logic [15:0] weight_i,
  input  logic [31:0] new_position_i,
  input  logic [9:0]  budget_i,
  input  logic [6:0]  room_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] victim_position_o,
  output logic        victim_valid_o,
  output logic        last_o,
  output logic [9:0]  size_after_o
);

  ate_pkg::cmd_t cmd;
  ate_pkg::sts_t sts;

  ate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ate_dpath #(
    .SLOTS         (SLOTS),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (mode_i),
    .slot_index_i      (slot_index_i),
    .weight_i          (weight_i),
    .new_position_i    (new_position_i),
    .budget_i          (budget_i),
    .room_i            (room_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .victim_position_o (victim_position_o),
    .victim_valid_o    (victim_valid_o),
    .last_o            (last_o),
    .size_after_o      (size_after_o)
  );

endmodule

// ----- hw/rtl/ate_checker.sv -----
// port level checks for the token eviction table, bound to the top level
// depends on ate_pkg and attention_token_eviction_table

module ate_checker #(
  parameter int unsigned SLOTS = 512
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic [1:0]  status_o,
  input logic        victim_valid_o,
  input logic        last_o,
  input logic [9:0]  size_after_o
);

  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && victim_valid_o |-> status_o == ate_pkg::STATUS_OK)
    else $error("victim word with bad status");

  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !victim_valid_o |-> last_o)
    else $error("non-victim word not last");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(size_after_o) <= 32'(SLOTS))
    else $error("size beyond table");

  a_full_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ate_pkg::STATUS_FULL |-> 32'(size_after_o) == 32'(SLOTS))
    else $error("full status with room left");

endmodule

bind attention_token_eviction_table ate_checker #(.SLOTS(SLOTS)) u_ate_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .status_o       (status_o),
  .victim_valid_o (victim_valid_o),
  .last_o         (last_o),
  .size_after_o   (size_after_o)
);
